// ===== hdl/vn_pkg.sv =====
// package for the 3d vector normalizer: widths, payload structs
`default_nettype none
package vn_pkg;

	// fraction bits of the fixed point format
	localparam int FRAC_BITS = 16;
	// width of a component and of a square
	localparam int CW = 32;
	localparam int SW = 2 * CW;
	// width of the scaled square used as comparison bound
	localparam int RW = SW + 2 * FRAC_BITS;
	// width of a trial product and of the running m*m*s term
	localparam int TW = RW + 4;
	localparam int QW = SW + FRAC_BITS + 2;
	// width of the result magnitude (at most 1.0)
	localparam int MW = FRAC_BITS + 1;
	// number of result bits found one per stage
	localparam int NIT = FRAC_BITS + 1;

	// one vector request
	typedef struct packed {
		logic signed [CW-1:0] vec_x;
		logic signed [CW-1:0] vec_y;
		logic signed [CW-1:0] vec_z;
	} vec_t;

	// one result
	typedef struct packed {
		logic signed [CW-1:0] out_x;
		logic signed [CW-1:0] out_y;
		logic signed [CW-1:0] out_z;
		logic                 passed_through;
	} res_t;

endpackage
`default_nettype wire

// ===== hdl/vec3_normalize.sv =====
// top level of the 3d vector normalizer pipeline
`default_nettype none
// Normalizes one signed fixed point 3d vector per cycle. busy is always low, so a
// request is taken at every clock edge with start high; the result appears on res
// with done high for one cycle, in request order. The pipeline depth is set by the
// bitwise search for each normalized component: one result bit per pipeline stage,
// each stage one wide add and compare, all three components side by side. Vectors
// whose squared length lies within tolerance of 1.0 or of 0.0 come out unchanged
// with passed_through set. tolerance may only be written while no request is in
// flight.
module vec3_normalize (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire vn_pkg::vec_t  vec,
	input  wire logic          tol_we,
	input  wire logic [15:0]   tol_wdata,
	output logic               done,
	output vn_pkg::res_t       res
);
	import vn_pkg::*;

	logic [15:0] tol_q;

	// stage 1: magnitudes and signs
	logic          v_s1;
	logic [CW-1:0] raw_s1 [3];
	logic [CW-1:0] mag_s1 [3];
	// stage 2: squares
	logic          v_s2;
	logic [CW-1:0] raw_s2 [3];
	logic [SW-1:0] sq_s2  [3];
	// stage 3: squared length
	logic          v_s3;
	logic [CW-1:0] raw_s3 [3];
	logic [SW-1:0] sq_s3  [3];
	logic [SW-1:0] len_s3;

	// iteration pipeline, index 0 is stage 4
	logic          it_v_s    [NIT+1];
	logic          it_pass_s [NIT+1];
	logic [SW-1:0] it_len_s  [NIT+1];
	logic [CW-1:0] it_raw_s  [NIT+1][3];
	logic [RW-1:0] it_rhs_s  [NIT+1][3];
	logic [TW-1:0] it_p_s    [NIT+1][3];
	logic [QW-1:0] it_q_s    [NIT+1][3];
	logic [MW-1:0] it_m_s    [NIT+1][3];

	logic [CW-1:0] mag_in [3];
	logic [SW-1:0] one_c;
	logic [SW-1:0] tol_sc;
	logic [SW-1:0] dist_one;
	logic          near;
	logic [CW-1:0] fin [3];
	res_t          res_q;
	logic          done_q;

	assign busy = 1'b0;

	// tolerance register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= 16'd1;
		end else if (tol_we) begin
			tol_q <= tol_wdata;
		end
	end

	// absolute values of the incoming components
	always_comb begin
		mag_in[0] = vec.vec_x[CW-1] ? CW'(-vec.vec_x) : CW'(vec.vec_x);
		mag_in[1] = vec.vec_y[CW-1] ? CW'(-vec.vec_y) : CW'(vec.vec_y);
		mag_in[2] = vec.vec_z[CW-1] ? CW'(-vec.vec_z) : CW'(vec.vec_z);
	end

	// front stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			it_v_s[0] <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			it_v_s[0] <= v_s3;
		end
	end

	// front stage data: abs, square, sum
	always_ff @(posedge clk) begin
		raw_s1[0] <= vec.vec_x;
		raw_s1[1] <= vec.vec_y;
		raw_s1[2] <= vec.vec_z;
		for (int i = 0; i < 3; i++) begin
			mag_s1[i] <= mag_in[i];
			raw_s2[i] <= raw_s1[i];
			sq_s2[i]  <= SW'(mag_s1[i]) * SW'(mag_s1[i]);
			raw_s3[i] <= raw_s2[i];
			sq_s3[i]  <= sq_s2[i];
		end
		len_s3 <= sq_s2[0] + sq_s2[1] + sq_s2[2];
	end

	// fuzzy compare against 1.0 and 0.0
	always_comb begin
		one_c    = SW'(1) << (2 * FRAC_BITS);
		tol_sc   = SW'(tol_q) << FRAC_BITS;
		dist_one = (len_s3 >= one_c) ? len_s3 - one_c : one_c - len_s3;
		near     = (len_s3 <= tol_sc) || (dist_one <= tol_sc);
	end

	// stage 4: pass flag and comparison bounds
	always_ff @(posedge clk) begin
		it_pass_s[0] <= near;
		it_len_s[0]  <= len_s3;
		for (int i = 0; i < 3; i++) begin
			it_raw_s[0][i] <= raw_s3[i];
			it_rhs_s[0][i] <= RW'(sq_s3[i]) << (2 * FRAC_BITS);
			it_p_s[0][i]   <= '0;
			it_q_s[0][i]   <= '0;
			it_m_s[0][i]   <= '0;
		end
	end

	// one result bit per stage, most significant first
	for (genvar k = 0; k < NIT; k++) begin : g_it
		localparam int B = FRAC_BITS - k;
		logic [TW-1:0] trial [3];
		logic          take  [3];

		// trial (m + 2^b)^2 * s built from running terms
		always_comb begin
			for (int i = 0; i < 3; i++) begin
				trial[i] = it_p_s[k][i] + (TW'(it_q_s[k][i]) << (B + 1))
				         + (TW'(it_len_s[k]) << (2 * B));
				take[i]  = trial[i] <= TW'(it_rhs_s[k][i]);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				it_v_s[k+1] <= 1'b0;
			end else begin
				it_v_s[k+1] <= it_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			it_pass_s[k+1] <= it_pass_s[k];
			it_len_s[k+1]  <= it_len_s[k];
			for (int i = 0; i < 3; i++) begin
				it_raw_s[k+1][i] <= it_raw_s[k][i];
				it_rhs_s[k+1][i] <= it_rhs_s[k][i];
				if (take[i]) begin
					it_p_s[k+1][i] <= trial[i];
					it_q_s[k+1][i] <= it_q_s[k][i] + (QW'(it_len_s[k]) << B);
					it_m_s[k+1][i] <= it_m_s[k][i] | (MW'(1) << B);
				end else begin
					it_p_s[k+1][i] <= it_p_s[k][i];
					it_q_s[k+1][i] <= it_q_s[k][i];
					it_m_s[k+1][i] <= it_m_s[k][i];
				end
			end
		end
	end

	// apply sign or pass the input through
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (it_pass_s[NIT]) begin
				fin[i] = it_raw_s[NIT][i];
			end else if (it_raw_s[NIT][i][CW-1]) begin
				fin[i] = CW'(-CW'(it_m_s[NIT][i]));
			end else begin
				fin[i] = CW'(it_m_s[NIT][i]);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= it_v_s[NIT];
		end
	end

	always_ff @(posedge clk) begin
		res_q.out_x          <= fin[0];
		res_q.out_y          <= fin[1];
		res_q.out_z          <= fin[2];
		res_q.passed_through <= it_pass_s[NIT];
	end

	assign done = done_q;
	assign res  = res_q;

	// a result strobe always follows a valid last iteration stage
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(it_v_s[NIT]))
		else $error("result strobe without request in last stage");

	// a zero vector always passes through
	a_zero_pass: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && (len_s3 == '0) |=> it_pass_s[0])
		else $error("zero vector not passed through");

	// the x component of a normalized result stays within plus or minus one
	a_unit: assert property (@(posedge clk) disable iff (!arst_n)
		done && !res.passed_through |->
		(res.out_x <= (CW'(1) << FRAC_BITS)) && (res.out_x >= -(CW'(1) << FRAC_BITS)))
		else $error("normalized component out of range");

	// the x result magnitude of a normalized vector never exceeds 1.0
	a_mag: assert property (@(posedge clk) disable iff (!arst_n)
		it_v_s[NIT] && !it_pass_s[NIT] |-> (it_m_s[NIT][0] <= (MW'(1) << FRAC_BITS)))
		else $error("result magnitude above one");

endmodule
`default_nettype wire

// ===== tb/vec3_normalize_tb.sv =====
// testbench for the 3d vector normalizer: directed and random vectors against a predictor
`timescale 1ns / 100ps
`default_nettype none
module vec3_normalize_tb;
	import vn_pkg::*;

	localparam int LATENCY = FRAC_BITS + 6;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	vec_t vec;
	logic tol_we;
	logic [15:0] tol_wdata;
	logic done;
	res_t res;

	// tolerance copy held by the predictor
	logic [15:0] tol_model;
	res_t expected_q[$];
	int n_errors;
	int send_idle_pct;

	vec3_normalize dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .vec(vec),
		.tol_we(tol_we), .tol_wdata(tol_wdata), .done(done), .res(res)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog
	initial begin
		#20ms;
		$display("Regression FAIL");
		$finish;
	end

	// largest m with m*m*s <= c*c*2^(2F), found bit by bit
	function automatic logic [31:0] unit_magnitude(input logic [31:0] mag, input logic [63:0] s);
		logic [127:0] bound;
		logic [63:0] m;
		logic [63:0] t;
		bound = ({96'd0, mag} * {96'd0, mag}) << (2 * FRAC_BITS);
		m = '0;
		for (int b = FRAC_BITS; b >= 0; b--) begin
			t = m | (64'd1 << b);
			if ({64'd0, t * t} * {64'd0, s} <= bound)
				m = t;
		end
		return m[31:0];
	endfunction

	// expected result for one vector under the current tolerance
	function automatic res_t normalize_predict(input vec_t v);
		logic [31:0] comp[3];
		logic [31:0] mag[3];
		logic [63:0] s, one, tol, gap, m;
		res_t r;
		comp[0] = v.vec_x;
		comp[1] = v.vec_y;
		comp[2] = v.vec_z;
		s = '0;
		for (int i = 0; i < 3; i++) begin
			mag[i] = comp[i][31] ? -comp[i] : comp[i];
			s += {32'd0, mag[i]} * {32'd0, mag[i]};
		end
		one = 64'd1 << (2 * FRAC_BITS);
		tol = {48'd0, tol_model} << FRAC_BITS;
		gap = (s >= one) ? s - one : one - s;
		if (s <= tol || gap <= tol) begin
			r.out_x = v.vec_x;
			r.out_y = v.vec_y;
			r.out_z = v.vec_z;
			r.passed_through = 1'b1;
		end else begin
			for (int i = 0; i < 3; i++) begin
				m = {32'd0, unit_magnitude(mag[i], s)};
				comp[i] = comp[i][31] ? -m[31:0] : m[31:0];
			end
			r.out_x = comp[0];
			r.out_y = comp[1];
			r.out_z = comp[2];
			r.passed_through = 1'b0;
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
		n_errors++;
	endtask

	// result checker
	always @(posedge clk) begin
		res_t want;
		if (arst_n && done) begin
			if (expected_q.size() == 0) begin
				report_mismatch("unexpected result", res.out_x, 32'd0);
			end else begin
				want = expected_q.pop_front();
				if (res.out_x !== want.out_x) report_mismatch("out_x", res.out_x, want.out_x);
				if (res.out_y !== want.out_y) report_mismatch("out_y", res.out_y, want.out_y);
				if (res.out_z !== want.out_z) report_mismatch("out_z", res.out_z, want.out_z);
				if (res.passed_through !== want.passed_through)
					report_mismatch("passed_through", {31'd0, res.passed_through},
						{31'd0, want.passed_through});
			end
		end
	end

	// send one request, with random idle cycles ahead of it
	task automatic send_vector(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
		vec_t v;
		while ($urandom_range(99) < send_idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		v.vec_x = x;
		v.vec_y = y;
		v.vec_z = z;
		start <= 1'b1;
		vec <= v;
		@(posedge clk);
		while (busy) @(posedge clk);
		expected_q.push_back(normalize_predict(v));
		@(negedge clk);
	endtask

	// wait for the pipeline to drain, then past its latency
	task automatic drain_pipeline();
		start <= 1'b0;
		while (expected_q.size() != 0) @(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	task automatic write_tolerance(input logic [15:0] value);
		drain_pipeline();
		tol_we <= 1'b1;
		tol_wdata <= value;
		@(negedge clk);
		tol_model = value;
		tol_we <= 1'b0;
	endtask

	function automatic logic [31:0] random_component();
		case ($urandom_range(5))
			0: return $urandom();
			1: return $urandom_range(131072) - 65536;
			2: return $urandom_range(4096) - 2048;
			3: return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
			default: return $urandom_range(2000000) - 1000000;
		endcase
	endfunction

	task automatic test_extremes();
		send_vector(0, 0, 0);
		send_vector(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_vector(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
		send_vector(32'h8000_0000, 0, 32'h7fff_ffff);
		send_vector(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
		send_vector(1, 0, 0);
		send_vector(32'h0001_0000, 0, 0);
		send_vector(0, 32'hffff_0000, 0);
		send_vector(0, 0, 32'h0002_0000);
		send_vector(32'h0000_b505, 32'h0000_b505, 0);
		send_vector(32'h0003_0000, 32'hfffc_0000, 32'h000c_0000);
		send_vector(32'h0001_0001, 0, 0);
		send_vector(32'h0000_ffff, 0, 0);
	endtask

	// vectors just inside and outside the tolerance band around 1.0 and 0.0
	task automatic test_tolerance_edges();
		logic [15:0] tols[4] = '{16'd0, 16'd1, 16'd300, 16'hffff};
		foreach (tols[i]) begin
			write_tolerance(tols[i]);
			send_vector(32'h0001_0000, 0, 0);
			send_vector(32'h0001_0000 + (tols[i] >> 1), 0, 0);
			send_vector(32'h0001_0000 - (tols[i] >> 1) - 1, 0, 0);
			send_vector(0, $urandom_range(300), 0);
			send_vector(0, 0, {16'd0, tols[i]});
			send_vector($urandom(), $urandom(), $urandom());
		end
	endtask

	task automatic test_random(input int count);
		for (int i = 0; i < count; i++) begin
			if (i == count / 2) drain_pipeline();
			send_vector(random_component(), random_component(), random_component());
		end
	endtask

	initial begin
		n_errors = 0;
		send_idle_pct = 36;
		tol_model = 16'd1;
		arst_n = 1'b0;
		start = 1'b0;
		vec = '0;
		tol_we = 1'b0;
		tol_wdata = '0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_extremes();
		test_tolerance_edges();
		write_tolerance(16'd1);
		test_random(600);
		send_idle_pct = 85;
		write_tolerance($urandom_range(65535));
		test_random(600);
		send_idle_pct = 0;
		write_tolerance(16'd0);
		test_random(600);
		drain_pipeline();
		if (n_errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule
`default_nettype wire
